// File: sv/smof_pkg.sv
`timescale 1ns / 1ps
// Shared constants and codes for the shifted mask open fraction core.
// No dependencies; used by the interfaces, the counter RAM and the core.
package smof_pkg;

   localparam int MASK_SIDE        = 1950;
   localparam int WINDOWS_PER_SIDE = 16;
   localparam int EDGE_W           = 114;
   localparam int INNER_W          = 123;

   localparam int NUM_WIN   = WINDOWS_PER_SIDE * WINDOWS_PER_SIDE;
   localparam int WIN_IDX_W = $clog2(WINDOWS_PER_SIDE);
   localparam int ADDR_W    = $clog2(NUM_WIN);

   localparam int OP_W       = 2;
   localparam int COORD_W    = 11;
   localparam int SHIFT_W    = 12;
   localparam int COUNT_W    = 14;
   localparam int FRAC_W     = 17;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = SHIFT_W;

   localparam int COUNT_MAX = (1 << COUNT_W) - 1;

   localparam int AREA_EE  = EDGE_W * EDGE_W;
   localparam int AREA_EI  = EDGE_W * INNER_W;
   localparam int AREA_II  = INNER_W * INNER_W;
   localparam int FRAC_Q   = 16;
   localparam int FRAC_ONE = 1 << FRAC_Q;

   // floor(v / INNER_W) for v < 2**COORD_W as (v * INNER_RECIP) >> INNER_DIV_SHIFT
   localparam int INNER_DIV_SHIFT = COORD_W + $clog2(INNER_W);
   localparam int INNER_RECIP     = ((1 << INNER_DIV_SHIFT) + INNER_W - 1) / INNER_W;
   localparam int INNER_RECIP_W   = $clog2(INNER_RECIP + 1);

   // floor((open << FRAC_Q) / area) as (open * recip) >> PROD_SHIFT, exact for open < 2**COUNT_W
   localparam int DIV_N       = COUNT_W + FRAC_Q;
   localparam int DIV_L       = $clog2(AREA_II);
   localparam int RECIP_SHIFT = DIV_N + DIV_L;
   localparam int RECIP_W     = DIV_N + 1;
   localparam int PROD_W      = COUNT_W + RECIP_W;
   localparam int PROD_SHIFT  = RECIP_SHIFT - FRAC_Q;

   localparam longint RECIP_EE = ((longint'(1) << RECIP_SHIFT) + AREA_EE - 1) / AREA_EE;
   localparam longint RECIP_EI = ((longint'(1) << RECIP_SHIFT) + AREA_EI - 1) / AREA_EI;
   localparam longint RECIP_II = ((longint'(1) << RECIP_SHIFT) + AREA_II - 1) / AREA_II;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR = 2'd0,
      OP_ACCUM = 2'd1,
      OP_READ  = 2'd2
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SHIFT_X      = 2'd0,
      CSR_SHIFT_Y      = 2'd1,
      CSR_CLOSED_VALUE = 2'd2
   } csr_type;

endpackage

// File: sv/smof_if.sv
`timescale 1ns / 1ps
// Valid/ready channels of the shifted mask open fraction core: request and response.
// Depends on smof_pkg for field widths.
interface smof_req_if;
   logic                               valid;
   logic                               ready;
   logic [smof_pkg::OP_W-1:0]          operation;
   logic [smof_pkg::COORD_W-1:0]       pixel_row;
   logic [smof_pkg::COORD_W-1:0]       pixel_col;
   logic                               pixel_value;
   logic [smof_pkg::WIN_IDX_W-1:0]     window_row;
   logic [smof_pkg::WIN_IDX_W-1:0]     window_col;

   modport source (
      output valid, operation, pixel_row, pixel_col, pixel_value, window_row, window_col,
      input  ready
   );
   modport sink (
      input  valid, operation, pixel_row, pixel_col, pixel_value, window_row, window_col,
      output ready
   );
endinterface

interface smof_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [smof_pkg::COUNT_W-1:0]       closed_count;
   logic [smof_pkg::COUNT_W-1:0]       window_pixels;
   logic [smof_pkg::FRAC_W-1:0]        open_fraction;

   modport source (
      output valid, closed_count, window_pixels, open_fraction,
      input  ready
   );
   modport sink (
      input  valid, closed_count, window_pixels, open_fraction,
      output ready
   );
endinterface

// File: sv/smof_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Defaults taken from smof_pkg.
module smof_ram #(
   parameter int WIDTH = smof_pkg::COUNT_W,
   parameter int DEPTH = smof_pkg::NUM_WIN
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read-first: a same-cycle write is not seen
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/shifted_mask_open_fraction_core.sv
`timescale 1ns / 1ps
// Shifted mask open fraction core: per-window ones counters over a shifted mask.
// A read passes the input register, stages 2 and 3, then the output register. Throughput:
// one item per cycle; back-to-back updates of one counter are forwarded around the RAM.
// Input stalls only while a read result waits in the last stage behind a full output.
// Reset (sync, active high) zeroes the shift and closed-value registers and drops all
// 256 counter valid bits at once, so every counter reads zero; no clearing pass.
module shifted_mask_open_fraction_core (
   input  logic                                clock,
   input  logic                                reset,
   smof_req_if.sink                            req_bus,
   smof_rsp_if.source                          rsp_bus,
   input  logic                                csr_wr_en,
   input  logic [smof_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [smof_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int POS_W  = smof_pkg::COORD_W + 2;
   localparam int DIVP_W = smof_pkg::COORD_W + smof_pkg::INNER_RECIP_W;

   // configuration
   logic signed [smof_pkg::SHIFT_W-1:0] shift_x_ff;
   logic signed [smof_pkg::SHIFT_W-1:0] shift_y_ff;
   logic                                closed_value_ff;

   // pipeline control
   logic stall;
   logic adv;

   // stage 1: input register
   logic                             s1_valid_ff;
   logic [smof_pkg::OP_W-1:0]        s1_op_ff;
   logic [smof_pkg::COORD_W-1:0]     s1_row_ff;
   logic [smof_pkg::COORD_W-1:0]     s1_col_ff;
   logic                             s1_value_ff;
   logic [smof_pkg::WIN_IDX_W-1:0]   s1_wrow_ff;
   logic [smof_pkg::WIN_IDX_W-1:0]   s1_wcol_ff;

   logic signed [POS_W-1:0]          row_pos;
   logic signed [POS_W-1:0]          col_pos;
   logic                             row_ok;
   logic                             col_ok;
   logic [smof_pkg::ADDR_W-1:0]      pix_addr;
   logic [smof_pkg::ADDR_W-1:0]      rd_addr;
   logic                             row_edge;
   logic                             col_edge;
   logic                             s2_inc_in;
   logic [smof_pkg::COUNT_W-1:0]     s2_area_in;
   logic [smof_pkg::RECIP_W-1:0]     s2_recip_in;
   logic                             s2_ones_valid_in;

   // stage 2: counter read-modify-write
   logic                             s2_valid_ff;
   logic [smof_pkg::OP_W-1:0]        s2_op_ff;
   logic                             s2_inc_ff;
   logic [smof_pkg::ADDR_W-1:0]      s2_addr_ff;
   logic [smof_pkg::COUNT_W-1:0]     s2_area_ff;
   logic [smof_pkg::RECIP_W-1:0]     s2_recip_ff;
   logic                             s2_ones_valid_ff;
   logic                             s2_clear;

   logic [smof_pkg::COUNT_W-1:0]     ram_q;
   logic                             wr_en;
   logic                             fwd_valid_ff;
   logic [smof_pkg::ADDR_W-1:0]      fwd_addr_ff;
   logic [smof_pkg::COUNT_W-1:0]     fwd_data_ff;
   logic                             fwd_hit;
   logic [smof_pkg::COUNT_W-1:0]     ones_cur;
   logic [smof_pkg::COUNT_W-1:0]     ones_next;
   logic [smof_pkg::NUM_WIN-1:0]     entry_valid_ff;

   logic [smof_pkg::COUNT_W-1:0]     s3_closed_in;
   logic [smof_pkg::COUNT_W-1:0]     s3_open_in;

   // stage 3: fraction multiply
   logic                             s3_valid_ff;
   logic [smof_pkg::COUNT_W-1:0]     s3_closed_ff;
   logic [smof_pkg::COUNT_W-1:0]     s3_area_ff;
   logic [smof_pkg::COUNT_W-1:0]     s3_open_ff;
   logic [smof_pkg::RECIP_W-1:0]     s3_recip_ff;
   logic [smof_pkg::PROD_W-1:0]      frac_prod;

   // output register
   logic                             out_valid_ff;
   logic [smof_pkg::COUNT_W-1:0]     out_closed_ff;
   logic [smof_pkg::COUNT_W-1:0]     out_area_ff;
   logic [smof_pkg::FRAC_W-1:0]      out_frac_ff;

   // window index along one axis for an in-image position
   function automatic logic [smof_pkg::WIN_IDX_W-1:0] win_of(
      input logic [smof_pkg::COORD_W-1:0] p
   );
      logic [smof_pkg::COORD_W-1:0] v;
      logic [DIVP_W-1:0]            prod;
      v    = p - smof_pkg::COORD_W'(smof_pkg::EDGE_W);
      prod = DIVP_W'(v) * DIVP_W'(smof_pkg::INNER_RECIP);
      if (p < smof_pkg::COORD_W'(smof_pkg::EDGE_W)) begin
         return '0;
      end else if (p >= smof_pkg::COORD_W'(smof_pkg::MASK_SIDE - smof_pkg::EDGE_W)) begin
         return smof_pkg::WIN_IDX_W'(smof_pkg::WINDOWS_PER_SIDE - 1);
      end else begin
         return prod[smof_pkg::INNER_DIV_SHIFT +: smof_pkg::WIN_IDX_W]
                + smof_pkg::WIN_IDX_W'(1);
      end
   endfunction

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_x_ff      <= '0;
         shift_y_ff      <= '0;
         closed_value_ff <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            smof_pkg::CSR_SHIFT_X:      shift_x_ff      <= $signed(csr_wdata[smof_pkg::SHIFT_W-1:0]);
            smof_pkg::CSR_SHIFT_Y:      shift_y_ff      <= $signed(csr_wdata[smof_pkg::SHIFT_W-1:0]);
            smof_pkg::CSR_CLOSED_VALUE: closed_value_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- control
   // everything moves together unless a read result has nowhere to go
   assign stall         = out_valid_ff && !rsp_bus.ready && s3_valid_ff;
   assign adv           = !stall;
   assign req_bus.ready = adv;

   // ---------------------------------------------------------------- stage 1
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_op_ff    <= req_bus.operation;
         s1_row_ff   <= req_bus.pixel_row;
         s1_col_ff   <= req_bus.pixel_col;
         s1_value_ff <= req_bus.pixel_value;
         s1_wrow_ff  <= req_bus.window_row;
         s1_wcol_ff  <= req_bus.window_col;
      end
   end

   always_comb begin
      row_pos = $signed(POS_W'(s1_row_ff)) - POS_W'(shift_y_ff);
      col_pos = $signed(POS_W'(s1_col_ff)) - POS_W'(shift_x_ff);
      row_ok  = !row_pos[POS_W-1]
                && (row_pos[POS_W-2:0] < (POS_W-1)'(smof_pkg::MASK_SIDE));
      col_ok  = !col_pos[POS_W-1]
                && (col_pos[POS_W-2:0] < (POS_W-1)'(smof_pkg::MASK_SIDE));
      pix_addr = {win_of(row_pos[smof_pkg::COORD_W-1:0]),
                  win_of(col_pos[smof_pkg::COORD_W-1:0])};
      rd_addr   = (s1_op_ff == smof_pkg::OP_READ) ? {s1_wrow_ff, s1_wcol_ff} : pix_addr;
      s2_inc_in = s1_value_ff && row_ok && col_ok;

      row_edge = (s1_wrow_ff == '0)
                 || (s1_wrow_ff == smof_pkg::WIN_IDX_W'(smof_pkg::WINDOWS_PER_SIDE - 1));
      col_edge = (s1_wcol_ff == '0)
                 || (s1_wcol_ff == smof_pkg::WIN_IDX_W'(smof_pkg::WINDOWS_PER_SIDE - 1));
      case ({row_edge, col_edge})
         2'b11: begin
            s2_area_in  = smof_pkg::COUNT_W'(smof_pkg::AREA_EE);
            s2_recip_in = smof_pkg::RECIP_W'(smof_pkg::RECIP_EE);
         end
         2'b00: begin
            s2_area_in  = smof_pkg::COUNT_W'(smof_pkg::AREA_II);
            s2_recip_in = smof_pkg::RECIP_W'(smof_pkg::RECIP_II);
         end
         default: begin
            s2_area_in  = smof_pkg::COUNT_W'(smof_pkg::AREA_EI);
            s2_recip_in = smof_pkg::RECIP_W'(smof_pkg::RECIP_EI);
         end
      endcase

      // a clear leaving stage 2 this edge empties every counter
      s2_ones_valid_in = s2_clear ? 1'b0 : entry_valid_ff[rd_addr];
   end

   // ---------------------------------------------------------------- stage 2
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_op_ff         <= s1_op_ff;
         s2_inc_ff        <= s2_inc_in;
         s2_addr_ff       <= rd_addr;
         s2_area_ff       <= s2_area_in;
         s2_recip_ff      <= s2_recip_in;
         s2_ones_valid_ff <= s2_ones_valid_in;
      end
   end

   smof_ram #(
      .WIDTH (smof_pkg::COUNT_W),
      .DEPTH (smof_pkg::NUM_WIN)
   ) u_ones_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s2_addr_ff),
      .wr_data (ones_next),
      .rd_en   (adv),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   always_comb begin
      s2_clear  = s2_valid_ff && (s2_op_ff == smof_pkg::OP_CLEAR);
      wr_en     = adv && s2_valid_ff && (s2_op_ff == smof_pkg::OP_ACCUM) && s2_inc_ff;
      // the RAM read missed a write made on the same edge
      fwd_hit   = fwd_valid_ff && (fwd_addr_ff == s2_addr_ff);
      ones_cur  = fwd_hit ? fwd_data_ff : (s2_ones_valid_ff ? ram_q : '0);
      ones_next = (ones_cur == smof_pkg::COUNT_W'(smof_pkg::COUNT_MAX))
                  ? ones_cur : ones_cur + smof_pkg::COUNT_W'(1);

      if (closed_value_ff) begin
         s3_closed_in = ones_cur;
      end else begin
         s3_closed_in = (ones_cur >= s2_area_ff) ? '0 : s2_area_ff - ones_cur;
      end
      s3_open_in = (s3_closed_in >= s2_area_ff) ? '0 : s2_area_ff - s3_closed_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff   <= 1'b0;
         entry_valid_ff <= '0;
      end else if (adv) begin
         fwd_valid_ff <= wr_en;
         if (s2_clear) begin
            entry_valid_ff <= '0;
         end else if (wr_en) begin
            entry_valid_ff[s2_addr_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fwd_addr_ff <= s2_addr_ff;
         fwd_data_ff <= ones_next;
      end
   end

   // ---------------------------------------------------------------- stage 3
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff && (s2_op_ff == smof_pkg::OP_READ);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_closed_ff <= s3_closed_in;
         s3_area_ff   <= s2_area_ff;
         s3_open_ff   <= s3_open_in;
         s3_recip_ff  <= s2_recip_ff;
      end
   end

   assign frac_prod = smof_pkg::PROD_W'(s3_open_ff) * smof_pkg::PROD_W'(s3_recip_ff);

   // ---------------------------------------------------------------- output
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv && s3_valid_ff) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && s3_valid_ff) begin
         out_closed_ff <= s3_closed_ff;
         out_area_ff   <= s3_area_ff;
         out_frac_ff   <= frac_prod[smof_pkg::PROD_SHIFT +: smof_pkg::FRAC_W];
      end
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.closed_count  = out_closed_ff;
   assign rsp_bus.window_pixels = out_area_ff;
   assign rsp_bus.open_fraction = out_frac_ff;

`ifndef SYNTH
   a_ready_low_only_blocked: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> (rsp_bus.valid && !rsp_bus.ready))
      else $error("input held off without a blocked result");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (adv && s2_clear) |=> (entry_valid_ff == '0))
      else $error("counter left valid after clear");

   a_read_reaches_output: assert property (@(posedge clock) disable iff (reset)
      (adv && s3_valid_ff) |=> rsp_bus.valid)
      else $error("read item lost before output");

   a_area_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.window_pixels == smof_pkg::COUNT_W'(smof_pkg::AREA_EE)
                      || rsp_bus.window_pixels == smof_pkg::COUNT_W'(smof_pkg::AREA_EI)
                      || rsp_bus.window_pixels == smof_pkg::COUNT_W'(smof_pkg::AREA_II)))
      else $error("window area out of set");

   a_frac_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.open_fraction <= smof_pkg::FRAC_W'(smof_pkg::FRAC_ONE)))
      else $error("open fraction above one");
`endif

endmodule

// File: verif/shifted_mask_open_fraction_core_test.sv
`timescale 1ns / 1ps
// Self-checking bench for shifted_mask_open_fraction_core: directed and random
// items through the req/rsp channels, results checked against a window counter model.
// Depends on smof_pkg, smof_if.sv and the core RTL.

localparam logic [smof_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

typedef struct packed {
   logic [smof_pkg::OP_W-1:0]      operation;
   logic [smof_pkg::COORD_W-1:0]   pixel_row;
   logic [smof_pkg::COORD_W-1:0]   pixel_col;
   logic                           pixel_value;
   logic [smof_pkg::WIN_IDX_W-1:0] window_row;
   logic [smof_pkg::WIN_IDX_W-1:0] window_col;
} pixel_req_type;

typedef struct packed {
   logic [smof_pkg::COUNT_W-1:0] closed_count;
   logic [smof_pkg::COUNT_W-1:0] window_pixels;
   logic [smof_pkg::FRAC_W-1:0]  open_fraction;
} window_read_type;

class open_fraction_board;
   logic [smof_pkg::COUNT_W-1:0]        ones [smof_pkg::NUM_WIN];
   logic signed [smof_pkg::SHIFT_W-1:0] shift_x;
   logic signed [smof_pkg::SHIFT_W-1:0] shift_y;
   logic                                closed_value;
   window_read_type                     pending_reads [$];
   int                                  failures;

   function new();
      clear_counts();
      shift_x      = '0;
      shift_y      = '0;
      closed_value = 1'b0;
      failures     = 0;
   endfunction

   static function int window_of(int p);
      if (p < smof_pkg::EDGE_W) return 0;
      if (p >= smof_pkg::MASK_SIDE - smof_pkg::EDGE_W) return smof_pkg::WINDOWS_PER_SIDE - 1;
      return 1 + (p - smof_pkg::EDGE_W) / smof_pkg::INNER_W;
   endfunction

   static function int window_span(int w);
      return (w == 0 || w == smof_pkg::WINDOWS_PER_SIDE - 1) ? smof_pkg::EDGE_W
                                                              : smof_pkg::INNER_W;
   endfunction

   static function int window_start(int w);
      return (w == 0) ? 0 : smof_pkg::EDGE_W + (w - 1) * smof_pkg::INNER_W;
   endfunction

   function void clear_counts();
      foreach (ones[i]) ones[i] = '0;
   endfunction

   function void write_reg(smof_pkg::csr_type idx, logic [smof_pkg::CSR_DATA_W-1:0] data);
      case (idx)
         smof_pkg::CSR_SHIFT_X:      shift_x = data;
         smof_pkg::CSR_SHIFT_Y:      shift_y = data;
         smof_pkg::CSR_CLOSED_VALUE: closed_value = data[0];
         default: ;
      endcase
   endfunction

   function void note_item(pixel_req_type it);
      int              r;
      int              c;
      int              slot;
      int              area;
      int              ones_v;
      int              closed;
      int              open_px;
      window_read_type want;
      case (it.operation)
         smof_pkg::OP_CLEAR: clear_counts();
         smof_pkg::OP_ACCUM: begin
            r = int'(it.pixel_row) - int'(shift_y);
            c = int'(it.pixel_col) - int'(shift_x);
            if (it.pixel_value && r >= 0 && r < smof_pkg::MASK_SIDE
                && c >= 0 && c < smof_pkg::MASK_SIDE) begin
               slot = window_of(r) * smof_pkg::WINDOWS_PER_SIDE + window_of(c);
               // counters saturate
               if (ones[slot] != smof_pkg::COUNT_MAX) ones[slot] = ones[slot] + 1'b1;
            end
         end
         smof_pkg::OP_READ: begin
            slot   = int'(it.window_row) * smof_pkg::WINDOWS_PER_SIDE + int'(it.window_col);
            area   = window_span(it.window_row) * window_span(it.window_col);
            ones_v = int'(ones[slot]);
            if (closed_value) closed = ones_v;
            else closed = (ones_v >= area) ? 0 : area - ones_v;
            open_px = (closed >= area) ? 0 : area - closed;
            want.closed_count  = smof_pkg::COUNT_W'(closed);
            want.window_pixels = smof_pkg::COUNT_W'(area);
            want.open_fraction = smof_pkg::FRAC_W'((longint'(open_px) << smof_pkg::FRAC_Q) / area);
            pending_reads = {pending_reads, want};
         end
         default: ;
      endcase
   endfunction

   function void check_read(logic [smof_pkg::COUNT_W-1:0] closed,
                            logic [smof_pkg::COUNT_W-1:0] area,
                            logic [smof_pkg::FRAC_W-1:0] frac);
      window_read_type want;
      if (pending_reads.size() == 0) begin
         $display("%0t: unexpected read item: closed_count %0d window_pixels %0d open_fraction %0d",
                  $time, closed, area, frac);
         failures++;
         return;
      end
      want = pending_reads.pop_front();
      if (closed !== want.closed_count) begin
         $display("%0t: closed_count expected %0d actual %0d", $time, want.closed_count, closed);
         failures++;
      end
      if (area !== want.window_pixels) begin
         $display("%0t: window_pixels expected %0d actual %0d", $time, want.window_pixels, area);
         failures++;
      end
      if (frac !== want.open_fraction) begin
         $display("%0t: open_fraction expected %0d actual %0d", $time, want.open_fraction, frac);
         failures++;
      end
   endfunction
endclass

module shifted_mask_open_fraction_core_test;

   localparam int STALL_CYCLES = 64;
   localparam int SETTLE       = 8;

   logic                            clock;
   logic                            reset;
   logic                            csr_wr_en;
   smof_pkg::csr_type               csr_index;
   logic [smof_pkg::CSR_DATA_W-1:0] csr_wdata;

   smof_req_if req_bus ();
   smof_rsp_if rsp_bus ();

   open_fraction_board board = new();

   int src_idle_pct;
   int sink_idle_pct;
   int stall_requests;
   int hot_row [3];
   int hot_col [3];

   shifted_mask_open_fraction_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      #10ms;
      $display("TEST FAILED");
      $finish;
   end

   // receiver: random back-pressure plus an occasional long hold-off
   initial begin
      int stalls_seen;
      int stall_left;
      stalls_seen   = 0;
      stall_left    = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_requests != stalls_seen) begin
            stalls_seen = stall_requests;
            stall_left  = STALL_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         board.check_read(rsp_bus.closed_count, rsp_bus.window_pixels, rsp_bus.open_fraction);
   end

   task automatic send_item(pixel_req_type it);
      @(negedge clock);
      while ($urandom_range(0, 99) < src_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.operation   <= it.operation;
      req_bus.pixel_row   <= it.pixel_row;
      req_bus.pixel_col   <= it.pixel_col;
      req_bus.pixel_value <= it.pixel_value;
      req_bus.window_row  <= it.window_row;
      req_bus.window_col  <= it.window_col;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      board.note_item(it);
   endtask

   task automatic send_accum(int r, int c, bit v);
      pixel_req_type it;
      it             = '0;
      it.operation   = smof_pkg::OP_ACCUM;
      it.pixel_row   = smof_pkg::COORD_W'(r);
      it.pixel_col   = smof_pkg::COORD_W'(c);
      it.pixel_value = v;
      send_item(it);
   endtask

   task automatic send_read(int wr, int wc);
      pixel_req_type it;
      it            = '0;
      it.operation  = smof_pkg::OP_READ;
      it.window_row = smof_pkg::WIN_IDX_W'(wr);
      it.window_col = smof_pkg::WIN_IDX_W'(wc);
      send_item(it);
   endtask

   task automatic send_op(logic [smof_pkg::OP_W-1:0] op);
      pixel_req_type it;
      it.operation   = op;
      it.pixel_row   = smof_pkg::COORD_W'($urandom_range(0, 2047));
      it.pixel_col   = smof_pkg::COORD_W'($urandom_range(0, 2047));
      it.pixel_value = 1'($urandom_range(0, 1));
      it.window_row  = smof_pkg::WIN_IDX_W'($urandom_range(0, 15));
      it.window_col  = smof_pkg::WIN_IDX_W'($urandom_range(0, 15));
      send_item(it);
   endtask

   // drop valid, wait for all reads to come back, then let accumulates retire
   task automatic drain();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (board.pending_reads.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(smof_pkg::csr_type idx, logic [smof_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      board.write_reg(idx, data);
   endtask

   task automatic set_config(int sx, int sy, bit cv);
      write_reg(smof_pkg::CSR_SHIFT_X, smof_pkg::CSR_DATA_W'(sx));
      write_reg(smof_pkg::CSR_SHIFT_Y, smof_pkg::CSR_DATA_W'(sy));
      write_reg(smof_pkg::CSR_CLOSED_VALUE, smof_pkg::CSR_DATA_W'(cv));
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // mostly accumulates aimed into the image after the shift, some into a few hot windows
   function automatic pixel_req_type random_item();
      pixel_req_type it;
      int            pick;
      int            h;
      int            tr;
      int            tc;
      int            raw_r;
      int            raw_c;
      it.pixel_row   = smof_pkg::COORD_W'($urandom_range(0, 2047));
      it.pixel_col   = smof_pkg::COORD_W'($urandom_range(0, 2047));
      it.pixel_value = 1'($urandom_range(0, 1));
      it.window_row  = smof_pkg::WIN_IDX_W'($urandom_range(0, 15));
      it.window_col  = smof_pkg::WIN_IDX_W'($urandom_range(0, 15));
      pick = $urandom_range(0, 99);
      h    = $urandom_range(0, 2);
      if (pick < 3) begin
         it.operation = smof_pkg::OP_CLEAR;
      end else if (pick < 6) begin
         it.operation = OP_UNUSED;
      end else if (pick < 30) begin
         it.operation = smof_pkg::OP_READ;
         if ($urandom_range(0, 1)) begin
            it.window_row = smof_pkg::WIN_IDX_W'(hot_row[h]);
            it.window_col = smof_pkg::WIN_IDX_W'(hot_col[h]);
         end
      end else begin
         it.operation   = smof_pkg::OP_ACCUM;
         it.pixel_value = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 3) != 0) begin
            if ($urandom_range(0, 1)) begin
               tr = board.window_start(hot_row[h]) +
                    $urandom_range(0, board.window_span(hot_row[h]) - 1);
               tc = board.window_start(hot_col[h]) +
                    $urandom_range(0, board.window_span(hot_col[h]) - 1);
            end else begin
               tr = $urandom_range(0, smof_pkg::MASK_SIDE - 1);
               tc = $urandom_range(0, smof_pkg::MASK_SIDE - 1);
            end
            raw_r = tr + int'(board.shift_y);
            raw_c = tc + int'(board.shift_x);
            if (raw_r >= 0 && raw_r < (1 << smof_pkg::COORD_W))
               it.pixel_row = raw_r[smof_pkg::COORD_W-1:0];
            if (raw_c >= 0 && raw_c < (1 << smof_pkg::COORD_W))
               it.pixel_col = raw_c[smof_pkg::COORD_W-1:0];
         end
      end
      return it;
   endfunction

   initial begin
      int phase_sx [6];
      int phase_sy [6];
      int phase_cv [6];
      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_index           = smof_pkg::CSR_SHIFT_X;
      csr_wdata           = '0;
      req_bus.valid       = 1'b0;
      req_bus.operation   = smof_pkg::OP_CLEAR;
      req_bus.pixel_row   = '0;
      req_bus.pixel_col   = '0;
      req_bus.pixel_value = 1'b0;
      req_bus.window_row  = '0;
      req_bus.window_col  = '0;
      src_idle_pct        = 0;
      sink_idle_pct       = 0;
      stall_requests      = 0;
      phase_sx = '{0, -1950, 1950, 0, -1, 0};
      phase_sy = '{0, 1950, -1950, 0, 1, 0};
      phase_cv = '{0, 1, 0, 0, 1, 0};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset values: no shift, closed value 0; window edges on both axes
      send_read(0, 0);
      send_accum(0, 0, 1'b1);
      send_accum(113, 113, 1'b1);
      send_accum(114, 114, 1'b1);
      send_accum(1835, 1836, 1'b1);
      send_accum(1949, 1949, 1'b1);
      send_accum(1950, 5, 1'b1);
      send_accum(2047, 2047, 1'b1);
      send_accum(5, 5, 1'b0);
      send_op(OP_UNUSED);
      send_read(0, 0);
      send_read(1, 1);
      send_read(14, 15);
      send_read(15, 15);
      send_op(smof_pkg::OP_CLEAR);
      send_read(15, 15);
      drain();

      // positive shift of one mask side: only raw coordinates at or above the mask side land
      set_config(1950, 1950, 1'b1);
      send_accum(2047, 2047, 1'b1);
      send_accum(1950, 1950, 1'b1);
      send_accum(1949, 2000, 1'b1);
      send_read(0, 0);
      drain();

      // negative shift of one mask side pushes everything out
      set_config(-1950, -1950, 1'b0);
      send_accum(0, 0, 1'b1);
      send_read(0, 0);

      for (int p = 0; p < 6; p++) begin
         drain();
         if (p == 3 || p == 5) begin
            phase_sx[p] = int'($urandom_range(0, 3900)) - 1950;
            phase_sy[p] = int'($urandom_range(0, 3900)) - 1950;
            phase_cv[p] = $urandom_range(0, 1);
         end
         set_config(phase_sx[p], phase_sy[p], phase_cv[p][0]);
         src_idle_pct  = (p < 2) ? 11 : (p < 4) ? 79 : 0;
         sink_idle_pct = (p < 2) ? 79 : (p < 4) ? 11 : 0;
         for (int h = 0; h < 3; h++) begin
            hot_row[h] = $urandom_range(0, 15);
            hot_col[h] = $urandom_range(0, 15);
         end
         if (p == 5) begin
            // long receiver hold-off while reads keep coming: fills the pipe
            stall_requests++;
            repeat (24) send_read($urandom_range(0, 15), $urandom_range(0, 15));
         end
         repeat (100) send_item(random_item());
      end
      drain();

      if (board.failures == 0 && board.pending_reads.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
sv/smof_pkg.sv
sv/smof_if.sv
sv/smof_ram.sv
sv/shifted_mask_open_fraction_core.sv
verif/shifted_mask_open_fraction_core_test.sv
